// ===== hdl/sule_pkg.sv =====
// Package: shared constants, codes and structs for the sorted unique list engine.
package sule_pkg;

  localparam int DEPTH   = 16;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int VAL_W   = 32;
  localparam int OP_W    = 2;
  localparam int ST_W    = 3;
  localparam int POS_W   = 4;
  localparam int COUNT_W = 5;
  localparam int CAP_W   = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_SEARCH = 2'd2,
    OP_RSVD   = 2'd3
  } sule_op_t;

  typedef enum logic [ST_W-1:0] {
    ST_INSERTED = 3'd0,
    ST_PRESENT  = 3'd1,
    ST_FULL     = 3'd2,
    ST_REMOVED  = 3'd3,
    ST_NOTFOUND = 3'd4,
    ST_FOUND    = 3'd5
  } sule_status_t;

  // Broadcast to every cell each cycle.
  typedef struct packed {
    logic                    ins;   // insert takes place
    logic                    rem;   // remove takes place
    logic signed [VAL_W-1:0] value;
  } sule_cmd_t;

  // What a cell shows its neighbors.
  typedef struct packed {
    logic signed [VAL_W-1:0] entry;
    logic                    valid;
    logic                    le;    // valid and entry <= value
  } sule_nbr_t;

endpackage

// ===== hdl/sule_if.sv =====
// Interfaces: request, result and configuration channels.
interface sule_in_if;
  logic                                valid;
  logic                                ready;
  logic [sule_pkg::OP_W-1:0]           op;
  logic signed [sule_pkg::VAL_W-1:0]   value;
  modport source (output valid, output op, output value, input ready);
  modport sink   (input valid, input op, input value, output ready);
endinterface

interface sule_out_if;
  logic                                valid;
  logic                                ready;
  logic [sule_pkg::ST_W-1:0]           status;
  logic [sule_pkg::POS_W-1:0]          position;
  logic [sule_pkg::COUNT_W-1:0]        count;
  modport source (output valid, output status, output position, output count, input ready);
  modport sink   (input valid, input status, input position, input count, output ready);
endinterface

interface sule_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [sule_pkg::CAP_W-1:0]          data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/sule_cell.sv =====
// One list slot: holds an entry, compares it with the request, shifts with neighbors.
module sule_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  sule_pkg::sule_cmd_t cmd,
  input  sule_pkg::sule_nbr_t left,
  input  sule_pkg::sule_nbr_t right,
  output sule_pkg::sule_nbr_t self,
  output logic                lt,
  output logic                eq
);
  import sule_pkg::*;

  logic signed [VAL_W-1:0] entry_r, entry_nxt;
  logic                    valid_r, valid_nxt;
  logic                    le;

  assign le = valid_r && (entry_r <= cmd.value);
  assign lt = valid_r && (entry_r < cmd.value);
  assign eq = valid_r && (entry_r == cmd.value);

  assign self.entry = entry_r;
  assign self.valid = valid_r;
  assign self.le    = le;

  always_comb begin
    entry_nxt = entry_r;
    valid_nxt = valid_r;
    if (cmd.ins && !le) begin
      // first slot past the smaller entries takes the value, the rest shift up
      entry_nxt = left.le ? cmd.value : left.entry;
      valid_nxt = left.valid;
    end else if (cmd.rem && !lt) begin
      entry_nxt = right.entry;
      valid_nxt = right.valid;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

endmodule

// ===== hdl/sorted_unique_list_engine.sv =====
// Top level: sorted unique list engine built as a row of compare-and-shift cells.
// The list lives in a row of DEPTH identical cells, slot 0 holding the smallest
// value. Every request is broadcast to all cells at once; each cell compares its
// entry against the value and, on an insert or remove, shifts in its left or
// right neighbor, so the whole list updates in the cycle the request is taken.
// One request is accepted per clock; the result appears on the out channel the
// next cycle and sits in a one-deep output register, so a stalled result only
// blocks new requests when the result has not been taken. Throughput is one
// transaction per cycle while results are taken. Capacity is written on the cfg
// channel (always ready, reset 16, values above DEPTH act as DEPTH); write it only
// while no request is in flight.
module sorted_unique_list_engine (
  input  logic  clk,
  input  logic  rst_n,
  sule_in_if.sink    in_ch,
  sule_out_if.source out_ch,
  sule_cfg_if.sink   cfg_ch
);
  import sule_pkg::*;

  // capacity register
  logic [CAP_W-1:0] cap_r;
  logic [CNT_W-1:0] limit;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_ch.valid) begin
      cap_r <= cfg_ch.data;
    end
  end

  always_comb begin
    if (32'(cap_r) > DEPTH) begin
      limit = CNT_W'(DEPTH);
    end else begin
      limit = CNT_W'(cap_r);
    end
  end

  // request decode
  logic       take;
  sule_op_t   op;
  sule_cmd_t  cmd;
  logic       full, present;

  assign op   = sule_op_t'(in_ch.op);
  assign take = in_ch.valid && in_ch.ready;

  // cell row
  sule_nbr_t            nbr   [DEPTH];
  logic [DEPTH-1:0]     lt_v, eq_v, le_v, valid_v;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    sule_nbr_t lft, rgt;
    if (g == 0) begin : g_first
      // virtual left edge: always valid and below everything
      assign lft = '{entry: '0, valid: 1'b1, le: 1'b1};
    end else begin : g_mid
      assign lft = nbr[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign rgt = '{entry: '0, valid: 1'b0, le: 1'b0};
    end else begin : g_inner
      assign rgt = nbr[g+1];
    end

    sule_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .cmd   (cmd),
      .left  (lft),
      .right (rgt),
      .self  (nbr[g]),
      .lt    (lt_v[g]),
      .eq    (eq_v[g])
    );

    assign le_v[g]    = nbr[g].le;
    assign valid_v[g] = nbr[g].valid;
  end

  // element count
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full    = cnt_r >= limit;
  assign present = |eq_v;

  // slot encoders: match slot (one-hot eq) and insert slot (end of le prefix)
  logic [IDX_W-1:0] hit_idx, ins_idx;

  always_comb begin
    hit_idx = '0;
    ins_idx = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (eq_v[i]) begin
        hit_idx = hit_idx | IDX_W'(i);
      end
      if (!le_v[i] && (i == 0 || le_v[(i == 0) ? 0 : i - 1])) begin
        ins_idx = ins_idx | IDX_W'(i);
      end
    end
    // every cell holds an entry <= value (row full, insert refused): insert slot reads 0
    if (le_v == '1) begin
      ins_idx = '0;
    end
  end

  // result and command generation
  sule_status_t status;
  logic [POS_W-1:0] pos;

  always_comb begin
    cmd.ins   = 1'b0;
    cmd.rem   = 1'b0;
    cmd.value = in_ch.value;
    status    = ST_NOTFOUND;
    pos       = '0;
    cnt_nxt   = cnt_r;
    case (op)
      OP_INSERT: begin
        if (full) begin
          status = ST_FULL;
        end else if (present) begin
          status = ST_PRESENT;
        end else begin
          cmd.ins = take;
          status  = ST_INSERTED;
          pos     = POS_W'(ins_idx);
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      OP_REMOVE: begin
        if (present) begin
          cmd.rem = take;
          status  = ST_REMOVED;
          pos     = POS_W'(hit_idx);
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      OP_SEARCH: begin
        if (present) begin
          status = ST_FOUND;
          pos    = POS_W'(hit_idx);
        end
      end
      default: begin
        status = ST_NOTFOUND;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (take) begin
      cnt_r <= cnt_nxt;
    end
  end

  // output register; new request taken whenever it is empty or being drained
  logic                 out_valid_r;
  logic [ST_W-1:0]      status_r;
  logic [POS_W-1:0]     pos_r;
  logic [COUNT_W-1:0]   count_r;

  assign in_ch.ready = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      out_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      status_r <= status;
      pos_r    <= pos;
      count_r  <= COUNT_W'(cnt_nxt);
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.status   = status_r;
  assign out_ch.position = pos_r;
  assign out_ch.count    = count_r;

  // count tracks the occupied cells
  a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_v) == 32'(cnt_r))
    else $error("count differs from occupied cells");

  // occupied cells form a prefix of the row
  a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_v & (valid_v + DEPTH'(1))) == '0)
    else $error("occupied cells not packed");

  // entries below the value form a prefix of the row
  a_lt_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    (lt_v & (lt_v + DEPTH'(1))) == '0)
    else $error("list out of order");

  // distinct entries: at most one match
  a_unique: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(eq_v))
    else $error("duplicate entry in list");

  // a held result is not overwritten
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |=> out_valid_r && $stable(status_r) && $stable(pos_r))
    else $error("stalled result changed");

endmodule
